[design/tbb_pkg.sv]
// shared types and constants of the bounding box transform
package tbb_pkg;

   localparam int COEF_WIDTH      = 32;
   localparam int CSR_DATA_WIDTH  = 2 * COEF_WIDTH;
   localparam int NUM_CSR         = 6;
   localparam int CSR_INDEX_WIDTH = 3;
   localparam int NUM_AXES        = 3;

   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_ROW_X_AB = 3'd0;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_ROW_X_CS = 3'd1;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_ROW_Y_AB = 3'd2;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_ROW_Y_CS = 3'd3;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_ROW_Z_AB = 3'd4;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_ROW_Z_CS = 3'd5;

   typedef struct packed {
      logic valid;
      logic empty;
   } tbb_ctl_type;

endpackage

[design/tbb_lane.sv]
// one matrix row: split products, per-term min and max, saturated row sums
module tbb_lane #(
   parameter int COORD_WIDTH = 32,
   parameter int FRAC_BITS   = 16
) (
   input  logic                                  clock,
   input  logic                                  advance,
   input  logic signed [tbb_pkg::COEF_WIDTH-1:0] coef [3],
   input  logic signed [tbb_pkg::COEF_WIDTH-1:0] shift,
   input  logic signed [COORD_WIDTH-1:0]         box_low [3],
   input  logic signed [COORD_WIDTH-1:0]         box_high [3],
   output logic signed [COORD_WIDTH-1:0]         row_low,
   output logic signed [COORD_WIDTH-1:0]         row_high
);
   import tbb_pkg::*;

   localparam int LO_W = COORD_WIDTH / 2;
   localparam int HI_W = COORD_WIDTH - LO_W;
   localparam int LPW  = LO_W + 1 + COEF_WIDTH;
   localparam int HPW  = HI_W + COEF_WIDTH;
   localparam int PW   = COORD_WIDTH + COEF_WIDTH;
   localparam int TW   = PW - FRAC_BITS;
   localparam int SW   = ((TW > COEF_WIDTH) ? TW : COEF_WIDTH) + 2;
   localparam logic signed [SW-1:0] SAT_MAX =
      {{(SW-COORD_WIDTH+1){1'b0}}, {(COORD_WIDTH-1){1'b1}}};
   localparam logic signed [SW-1:0] SAT_MIN =
      {{(SW-COORD_WIDTH+1){1'b1}}, {(COORD_WIDTH-1){1'b0}}};

   logic signed [LPW-1:0] pp_lo_in [3][2];
   logic signed [LPW-1:0] pp_lo_ff [3][2];
   logic signed [HPW-1:0] pp_hi_in [3][2];
   logic signed [HPW-1:0] pp_hi_ff [3][2];
   logic signed [TW-1:0]  term_min_in [3];
   logic signed [TW-1:0]  term_min_ff [3];
   logic signed [TW-1:0]  term_max_in [3];
   logic signed [TW-1:0]  term_max_ff [3];
   logic signed [SW-1:0]  sum_min;
   logic signed [SW-1:0]  sum_max;

   // partial products: unsigned low slice and signed high slice of each bound
   always_comb begin
      logic signed [COORD_WIDTH-1:0] bound;
      logic signed [LO_W:0]          lo_part;
      logic signed [HI_W-1:0]        hi_part;
      for (int a = 0; a < 3; a++) begin
         for (int s = 0; s < 2; s++) begin
            bound = (s == 0) ? box_low[a] : box_high[a];
            lo_part = $signed({1'b0, bound[LO_W-1:0]});
            hi_part = $signed(bound[COORD_WIDTH-1:LO_W]);
            pp_lo_in[a][s] = LPW'(lo_part) * LPW'(coef[a]);
            pp_hi_in[a][s] = HPW'(hi_part) * HPW'(coef[a]);
         end
      end
   end

   // full product, floor shift, smaller and larger of the two corners
   always_comb begin
      logic signed [PW-1:0] prod;
      logic signed [TW-1:0] term [2];
      for (int a = 0; a < 3; a++) begin
         for (int s = 0; s < 2; s++) begin
            prod = (PW'(pp_hi_ff[a][s]) <<< LO_W) + PW'(pp_lo_ff[a][s]);
            term[s] = $signed(prod[PW-1:FRAC_BITS]);
         end
         term_min_in[a] = (term[0] < term[1]) ? term[0] : term[1];
         term_max_in[a] = (term[0] < term[1]) ? term[1] : term[0];
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         pp_lo_ff    <= pp_lo_in;
         pp_hi_ff    <= pp_hi_in;
         term_min_ff <= term_min_in;
         term_max_ff <= term_max_in;
      end
   end

   always_comb begin
      sum_min = SW'(shift) + SW'(term_min_ff[0]) + SW'(term_min_ff[1]) + SW'(term_min_ff[2]);
      sum_max = SW'(shift) + SW'(term_max_ff[0]) + SW'(term_max_ff[1]) + SW'(term_max_ff[2]);
      if (sum_min > SAT_MAX) begin
         row_low = SAT_MAX[COORD_WIDTH-1:0];
      end else if (sum_min < SAT_MIN) begin
         row_low = SAT_MIN[COORD_WIDTH-1:0];
      end else begin
         row_low = sum_min[COORD_WIDTH-1:0];
      end
      if (sum_max > SAT_MAX) begin
         row_high = SAT_MAX[COORD_WIDTH-1:0];
      end else if (sum_max < SAT_MIN) begin
         row_high = SAT_MIN[COORD_WIDTH-1:0];
      end else begin
         row_high = sum_max[COORD_WIDTH-1:0];
      end
   end

endmodule

[design/tbb_merge.sv]
// result register: collects the row lanes and substitutes the empty box
module tbb_merge #(
   parameter int COORD_WIDTH = 32
) (
   input  logic                          clock,
   input  logic                          reset,
   input  tbb_pkg::tbb_ctl_type          in_ctl,
   input  logic signed [COORD_WIDTH-1:0] row_low [3],
   input  logic signed [COORD_WIDTH-1:0] row_high [3],
   input  logic                          rsp_ready,
   output logic                          advance,
   output logic                          rsp_valid,
   output logic                          rsp_empty,
   output logic signed [COORD_WIDTH-1:0] rsp_low [3],
   output logic signed [COORD_WIDTH-1:0] rsp_high [3]
);
   import tbb_pkg::*;

   logic                          valid_ff;
   logic                          empty_ff;
   logic signed [COORD_WIDTH-1:0] low_in [3];
   logic signed [COORD_WIDTH-1:0] low_ff [3];
   logic signed [COORD_WIDTH-1:0] high_in [3];
   logic signed [COORD_WIDTH-1:0] high_ff [3];

   assign advance = !valid_ff || rsp_ready;

   always_comb begin
      for (int a = 0; a < 3; a++) begin
         low_in[a]  = in_ctl.empty ? '0 : row_low[a];
         high_in[a] = in_ctl.empty ? '1 : row_high[a];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (advance) begin
         valid_ff <= in_ctl.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         empty_ff <= in_ctl.empty;
         low_ff   <= low_in;
         high_ff  <= high_in;
      end
   end

   assign rsp_valid = valid_ff;
   assign rsp_empty = empty_ff;
   assign rsp_low   = low_ff;
   assign rsp_high  = high_ff;

endmodule

[design/transform_bounding_box.sv]
// affine transform of an axis-aligned box, top level
// registers from an accepted word to rsp_valid: input, lane product, lane term, result
// throughput: one word per cycle unless rsp_ready stalls it, set by the per-row product pipeline
// (split multiply, product and min/max select, row sum into the result register)
// reset: clears all valid flags and loads the identity matrix with zero translation
module transform_bounding_box #(
   parameter int COORD_WIDTH = 32,
   parameter int FRAC_BITS   = 16
) (
   input  logic                                      clock,
   input  logic                                      reset,
   input  logic                                      req_valid,
   output logic                                      req_ready,
   input  logic signed [COORD_WIDTH-1:0]             req_x_low,
   input  logic signed [COORD_WIDTH-1:0]             req_x_high,
   input  logic signed [COORD_WIDTH-1:0]             req_y_low,
   input  logic signed [COORD_WIDTH-1:0]             req_y_high,
   input  logic signed [COORD_WIDTH-1:0]             req_z_low,
   input  logic signed [COORD_WIDTH-1:0]             req_z_high,
   output logic                                      rsp_valid,
   input  logic                                      rsp_ready,
   output logic signed [COORD_WIDTH-1:0]             rsp_new_x_low,
   output logic signed [COORD_WIDTH-1:0]             rsp_new_x_high,
   output logic signed [COORD_WIDTH-1:0]             rsp_new_y_low,
   output logic signed [COORD_WIDTH-1:0]             rsp_new_y_high,
   output logic signed [COORD_WIDTH-1:0]             rsp_new_z_low,
   output logic signed [COORD_WIDTH-1:0]             rsp_new_z_high,
   output logic                                      rsp_box_was_empty,
   input  logic                                      csr_valid,
   output logic                                      csr_ready,
   input  logic [tbb_pkg::CSR_INDEX_WIDTH-1:0]       csr_index,
   input  logic [tbb_pkg::CSR_DATA_WIDTH-1:0]        csr_data
);
   import tbb_pkg::*;

   localparam logic [COEF_WIDTH-1:0] COEF_ONE = COEF_WIDTH'(1) << FRAC_BITS;

   logic [CSR_DATA_WIDTH-1:0]     csr_in [NUM_CSR];
   logic [CSR_DATA_WIDTH-1:0]     csr_ff [NUM_CSR];
   logic signed [COORD_WIDTH-1:0] box_low_ff [3];
   logic signed [COORD_WIDTH-1:0] box_high_ff [3];
   logic signed [COORD_WIDTH-1:0] row_low [3];
   logic signed [COORD_WIDTH-1:0] row_high [3];
   logic signed [COORD_WIDTH-1:0] rsp_low [3];
   logic signed [COORD_WIDTH-1:0] rsp_high [3];
   tbb_ctl_type                   s0_ctl_in;
   tbb_ctl_type                   s0_ctl_ff;
   tbb_ctl_type                   s1_ctl_ff;
   tbb_ctl_type                   s2_ctl_ff;
   logic                          advance;
   logic                          accept;

   // configuration registers
   assign csr_ready = 1'b1;

   always_comb begin
      csr_in = csr_ff;
      if (csr_valid) begin
         case (csr_index)
            CSR_ROW_X_AB: csr_in[0] = csr_data;
            CSR_ROW_X_CS: csr_in[1] = csr_data;
            CSR_ROW_Y_AB: csr_in[2] = csr_data;
            CSR_ROW_Y_CS: csr_in[3] = csr_data;
            CSR_ROW_Z_AB: csr_in[4] = csr_data;
            CSR_ROW_Z_CS: csr_in[5] = csr_data;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         csr_ff[0] <= {{COEF_WIDTH{1'b0}}, COEF_ONE};
         csr_ff[1] <= '0;
         csr_ff[2] <= {COEF_ONE, {COEF_WIDTH{1'b0}}};
         csr_ff[3] <= '0;
         csr_ff[4] <= '0;
         csr_ff[5] <= {{COEF_WIDTH{1'b0}}, COEF_ONE};
      end else begin
         csr_ff <= csr_in;
      end
   end

   // input stage
   assign req_ready = advance;
   assign accept    = req_valid && req_ready;

   always_comb begin
      s0_ctl_in.valid = req_valid;
      s0_ctl_in.empty = (req_x_low > req_x_high) || (req_y_low > req_y_high) ||
                        (req_z_low > req_z_high);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s0_ctl_ff <= '0;
         s1_ctl_ff <= '0;
         s2_ctl_ff <= '0;
      end else if (advance) begin
         s0_ctl_ff <= s0_ctl_in;
         s1_ctl_ff <= s0_ctl_ff;
         s2_ctl_ff <= s1_ctl_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         box_low_ff[0]  <= req_x_low;
         box_high_ff[0] <= req_x_high;
         box_low_ff[1]  <= req_y_low;
         box_high_ff[1] <= req_y_high;
         box_low_ff[2]  <= req_z_low;
         box_high_ff[2] <= req_z_high;
      end
   end

   // one lane per output row
   for (genvar r = 0; r < NUM_AXES; r++) begin : g_lane
      logic signed [COEF_WIDTH-1:0] coef [3];
      logic signed [COEF_WIDTH-1:0] shift;

      assign coef[0] = $signed(csr_ff[2*r][COEF_WIDTH-1:0]);
      assign coef[1] = $signed(csr_ff[2*r][CSR_DATA_WIDTH-1:COEF_WIDTH]);
      assign coef[2] = $signed(csr_ff[2*r+1][COEF_WIDTH-1:0]);
      assign shift   = $signed(csr_ff[2*r+1][CSR_DATA_WIDTH-1:COEF_WIDTH]);

      tbb_lane #(
         .COORD_WIDTH (COORD_WIDTH),
         .FRAC_BITS   (FRAC_BITS)
      ) u_lane (
         .clock    (clock),
         .advance  (advance),
         .coef     (coef),
         .shift    (shift),
         .box_low  (box_low_ff),
         .box_high (box_high_ff),
         .row_low  (row_low[r]),
         .row_high (row_high[r])
      );
   end

   tbb_merge #(
      .COORD_WIDTH (COORD_WIDTH)
   ) u_merge (
      .clock     (clock),
      .reset     (reset),
      .in_ctl    (s2_ctl_ff),
      .row_low   (row_low),
      .row_high  (row_high),
      .rsp_ready (rsp_ready),
      .advance   (advance),
      .rsp_valid (rsp_valid),
      .rsp_empty (rsp_box_was_empty),
      .rsp_low   (rsp_low),
      .rsp_high  (rsp_high)
   );

   assign rsp_new_x_low  = rsp_low[0];
   assign rsp_new_x_high = rsp_high[0];
   assign rsp_new_y_low  = rsp_low[1];
   assign rsp_new_y_high = rsp_high[1];
   assign rsp_new_z_low  = rsp_low[2];
   assign rsp_new_z_high = rsp_high[2];

   // checks
   a_accept_enters: assert property (@(posedge clock) disable iff (reset)
      accept |=> s0_ctl_ff.valid)
      else $error("accepted word missing from input stage");

   a_empty_box: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_box_was_empty |->
         rsp_new_x_low == '0 && rsp_new_x_high == '1 &&
         rsp_new_y_low == '0 && rsp_new_y_high == '1 &&
         rsp_new_z_low == '0 && rsp_new_z_high == '1)
      else $error("empty word without the empty box");

   a_ordered_bounds: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_box_was_empty |->
         rsp_new_x_low <= rsp_new_x_high && rsp_new_y_low <= rsp_new_y_high &&
         rsp_new_z_low <= rsp_new_z_high)
      else $error("result low bound above high bound");

endmodule
